// ----- rtl/vktc_pkg.sv -----
package vktc_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int VER_W     = 16;
    localparam int PAY_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 3;
    localparam int IN_DATA_W = 88;
    localparam int OUT_DATA_W = 56;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    localparam logic [VER_W-1:0] VER_MAX = 16'hFFFF;

    // one table entry as held in the memory
    typedef struct packed {
        logic             live;
        logic [KEY_W-1:0] key;
        logic [VER_W-1:0] ver;
        logic [PAY_W-1:0] pay;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [VER_W-1:0]    ver;
        logic [PAY_W-1:0]    pay;
    } result_t;

endpackage

// ----- rtl/vktc_mem.sv -----
module vktc_mem #(
    parameter int SLOTS = 8,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  vktc_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output vktc_pkg::entry_t rdata
);

    vktc_pkg::entry_t mem [SLOTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/versioned_key_table_with_compaction.sv -----
// channel | ports            | fields, low bit up
// input   | s_axis_t*        | operation, key, version, payload
// result  | m_axis_t*        | status, slot, assigned_version, found_payload
//
// each item walks the slot memory one slot a cycle, and a new item is taken
// only once the result of the last one is accepted. a write that starts
// with the last slot used adds a compaction pass over every slot first.
// reset clears the fill count but not the memory, so no clearing pass is needed.
// the input is taken again the cycle after the result is accepted.
module versioned_key_table_with_compaction #(
    parameter int SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // operation, key, version, payload
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // status, slot, assigned_version, found_payload
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    // fill count: slots below it are used, the rest are not
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] ra_reg, ra_next;   // read address issued
    logic [CW-1:0] idx_reg, idx_next; // slot whose data is on rdata
    logic          rv_reg, rv_next;   // rdata valid
    logic [CW-1:0] dst_reg, dst_next;
    logic          cdone_reg, cdone_next;

    logic [vktc_pkg::OP_W-1:0]  op_reg;
    logic [vktc_pkg::KEY_W-1:0] key_reg;
    logic [vktc_pkg::VER_W-1:0] ver_reg;
    logic [vktc_pkg::PAY_W-1:0] pay_reg;

    logic                       any_reg, any_next;
    logic [vktc_pkg::VER_W-1:0] top_reg, top_next;
    logic                       hit_reg, hit_next;
    logic [AW-1:0]              hslot_reg, hslot_next;
    vktc_pkg::entry_t           hent_reg, hent_next;

    vktc_pkg::result_t res_reg, res_next;
    logic              mv_reg, mv_next;

    logic             we;
    logic [AW-1:0]    waddr;
    vktc_pkg::entry_t wdata, rdata;

    // read address goes in with its next value so data lines up with rv_reg
    vktc_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ra_next),
        .rdata (rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {3'b000, res_reg.pay, res_reg.ver, res_reg.slot, res_reg.status};

    logic [vktc_pkg::VER_W:0] nv_wide;
    logic [vktc_pkg::VER_W-1:0] nv;
    logic rd_live;

    always_comb begin
        nv_wide = any_reg ? ({1'b0, top_reg} + 17'd1) : 17'd1;
        nv      = nv_wide[vktc_pkg::VER_W] ? vktc_pkg::VER_MAX
                                             : nv_wide[vktc_pkg::VER_W-1:0];
        rd_live = rv_reg && (idx_reg < fill_reg) && rdata.live;
    end

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ra_next    = ra_reg;
        idx_next   = idx_reg;
        rv_next    = 1'b0;
        dst_next   = dst_reg;
        cdone_next = cdone_reg;
        any_next   = any_reg;
        top_next   = top_reg;
        hit_next   = hit_reg;
        hslot_next = hslot_reg;
        hent_next  = hent_reg;
        res_next   = res_reg;
        mv_next    = mv_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = rdata;

        if (mv_reg && m_axis_tready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    state_next = S_SCAN;
                    ra_next    = '0;
                    idx_next   = '0;
                    rv_next    = 1'b1;
                    any_next   = 1'b0;
                    top_next   = '0;
                    hit_next   = 1'b0;
                    cdone_next = 1'b0;
                end
            end
            S_SCAN: begin
                // rdata holds slot idx_reg; issue next read
                if (rv_reg) begin
                    if (rd_live && rdata.key == key_reg) begin
                        if (!any_reg || rdata.ver > top_reg) begin
                            top_next = rdata.ver;
                        end
                        any_next = 1'b1;
                        if (!hit_reg && rdata.ver == ver_reg) begin
                            hit_next   = 1'b1;
                            hslot_next = idx_reg[AW-1:0];
                            hent_next  = rdata;
                        end
                    end
                    if (idx_reg == FULL_CNT - CW'(1)) begin
                        state_next = S_DONE;
                    end else begin
                        idx_next = idx_reg + CW'(1);
                        ra_next  = ra_reg + AW'(1);
                        rv_next  = 1'b1;
                    end
                end
            end
            S_CMP: begin
                // stable move of live entries to the front
                if (rv_reg) begin
                    if (rd_live) begin
                        we       = 1'b1;
                        waddr    = dst_reg[AW-1:0];
                        wdata    = rdata;
                        dst_next = dst_reg + CW'(1);
                    end
                    if (idx_reg == FULL_CNT - CW'(1)) begin
                        fill_next  = rd_live ? dst_reg + CW'(1) : dst_reg;
                        cdone_next = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        idx_next = idx_reg + CW'(1);
                        ra_next  = ra_reg + AW'(1);
                        rv_next  = 1'b1;
                    end
                end
            end
            S_DONE: begin
                res_next = '{status: vktc_pkg::ST_NOT_FOUND, slot: '0, ver: '0, pay: '0};
                state_next = S_OUT;
                case (op_reg)
                    vktc_pkg::OP_WRITE: begin
                        if (fill_reg == FULL_CNT && !cdone_reg) begin
                            state_next = S_CMP;
                            dst_next   = '0;
                            ra_next    = '0;
                            idx_next   = '0;
                            rv_next    = 1'b1;
                        end else if (fill_reg == FULL_CNT) begin
                            res_next.status = vktc_pkg::ST_FULL;
                        end else begin
                            we          = 1'b1;
                            waddr       = fill_reg[AW-1:0];
                            wdata       = '{live: 1'b1, key: key_reg, ver: nv, pay: pay_reg};
                            fill_next   = fill_reg + CW'(1);
                            res_next.status = vktc_pkg::ST_OK;
                            res_next.slot   = 3'(fill_reg);
                            res_next.ver    = nv;
                        end
                    end
                    vktc_pkg::OP_FIND: begin
                        if (hit_reg) begin
                            res_next.status = vktc_pkg::ST_OK;
                            res_next.slot   = 3'(hslot_reg);
                            res_next.ver    = hent_reg.ver;
                            res_next.pay    = hent_reg.pay;
                        end
                    end
                    vktc_pkg::OP_DELETE: begin
                        if (hit_reg) begin
                            we         = 1'b1;
                            waddr      = hslot_reg;
                            wdata      = hent_reg;
                            wdata.live = 1'b0;
                            res_next.status = vktc_pkg::ST_OK;
                            res_next.slot   = 3'(hslot_reg);
                            res_next.ver    = hent_reg.ver;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_OUT: begin
                mv_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            mv_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            cdone_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            mv_reg    <= mv_next;
            rv_reg    <= rv_next;
            cdone_reg <= cdone_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg  <= s_axis_tdata[1:0];
            key_reg <= s_axis_tdata[33:2];
            ver_reg <= s_axis_tdata[49:34];
            pay_reg <= s_axis_tdata[81:50];
        end
        ra_reg    <= ra_next;
        idx_reg   <= idx_next;
        dst_reg   <= dst_next;
        any_reg   <= any_next;
        top_reg   <= top_next;
        hit_reg   <= hit_next;
        hslot_reg <= hslot_next;
        hent_reg  <= hent_next;
        res_reg   <= res_next;
    end

    logic unused_ok;
    assign unused_ok = ^s_axis_tdata[87:82];

endmodule
